>>> src/bpa_pkg.sv
// Package for the buffer pool allocator: payload structs, link memory request
// structs, operation and register codes, counter constants.
// No dependencies.
package bpa_pkg;

    localparam int HANDLE_W = 8;
    localparam int CNT_W    = 9;

    localparam logic [CNT_W-1:0] CNT_MAX     = 9'd511;
    localparam logic [CNT_W-1:0] LIMIT_RESET = 9'd16;
    localparam logic [CNT_W-1:0] LIMIT_MAX   = 9'd256;

    // Operation codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Register indexes (byte address = 4 * index)
    localparam logic REG_RECYCLE_LIMIT = 1'b0;

    typedef struct packed {
        logic                op;
        logic [HANDLE_W-1:0] handle_in;
    } in_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle_out;
        logic                ok;
        logic [CNT_W-1:0]    free_count;
        logic [CNT_W-1:0]    pending_count;
    } out_t;

    // Link memory read request
    typedef struct packed {
        logic                en;
        logic [HANDLE_W-1:0] idx;
    } link_rd_t;

    // Link memory write request
    typedef struct packed {
        logic                en;
        logic [HANDLE_W-1:0] idx;
        logic [HANDLE_W-1:0] data;
    } link_wr_t;

endpackage

>>> src/bpa_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module bpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/bpa_link_store.sv
// Next-pointer store: link RAM plus per-entry valid bits, so that an entry
// never written reads as its reset link (index + 1). Depends on bpa_pkg, bpa_ram.
module bpa_link_store #(
    parameter int POOL_SIZE = 256
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  bpa_pkg::link_rd_t  rd_req,
    input  bpa_pkg::link_wr_t  wr_req,
    output logic [bpa_pkg::HANDLE_W-1:0] rd_link
);

    import bpa_pkg::*;

    localparam int LINK_DEPTH = (POOL_SIZE < 256) ? POOL_SIZE : 256;
    localparam int ADDR_W     = $clog2(LINK_DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(LINK_DEPTH);

    logic [LINK_DEPTH-1:0] valid_reg;
    logic [LINK_DEPTH-1:0] valid_next;
    logic                  rd_valid_reg;
    logic [HANDLE_W-1:0]   rd_idx_reg;
    logic [HANDLE_W-1:0]   ram_rdata;
    logic                  wr_in_range;
    logic                  rd_in_range;
    logic                  rd_idx_in_range;
    logic [ADDR_W-1:0]     waddr;
    logic [ADDR_W-1:0]     raddr;

    assign wr_in_range     = {1'b0, wr_req.idx} < DEPTH_CNT;
    assign rd_in_range     = {1'b0, rd_req.idx} < DEPTH_CNT;
    assign rd_idx_in_range = {1'b0, rd_idx_reg} < DEPTH_CNT;
    assign waddr           = wr_req.idx[ADDR_W-1:0];
    assign raddr           = rd_req.idx[ADDR_W-1:0];

    bpa_ram #(
        .WIDTH (HANDLE_W),
        .DEPTH (LINK_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (wr_req.en && wr_in_range),
        .waddr (waddr),
        .wdata (wr_req.data),
        .re    (rd_req.en),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    // Valid bits: set on write, cleared by reset
    always_comb begin
        valid_next = valid_reg;
        if (wr_req.en && wr_in_range) begin
            valid_next[waddr] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Capture valid bit and index alongside the RAM read
    always_ff @(posedge aclk) begin
        if (rd_req.en) begin
            rd_valid_reg <= rd_in_range && valid_reg[raddr];
            rd_idx_reg   <= rd_req.idx;
        end
    end

    // Out-of-pool index reads as zero; unwritten entry reads as index + 1
    always_comb begin
        if (!rd_idx_in_range) begin
            rd_link = '0;
        end else if (rd_valid_reg) begin
            rd_link = ram_rdata;
        end else begin
            rd_link = rd_idx_reg + HANDLE_W'(1);
        end
    end

endmodule

>>> src/buffer_pool_allocator.sv
// Channel     | Direction | Handshake           | Payload
// ------------+-----------+---------------------+--------------------------------------
// s_ (ops)    | in        | s_valid / s_ready   | op, handle_in
// m_ (result) | out       | m_valid / m_ready   | handle_out, ok, free_count,
//             |           |                     | pending_count
// cfg (APB)   | in        | psel/penable/pready | recycle_limit at byte address 0
//
// An operation runs in steps: on accept the link of the free list head is read
// from the link RAM, then EXEC updates the lists and writes one link. A free that
// splices the recycle list onto a non-empty free list also passes through SPLICE
// for the second write on the single link RAM write port; onto an empty free
// list it needs no second write.
// A new operation is taken while a finished result still waits on m_; a stalled
// m_ holds the block only once the next result is ready. Reset is synchronous;
// the link RAM needs no clearing pass, valid bits supply the reset links.
// Depends on bpa_pkg, bpa_link_store, bpa_ram.
module buffer_pool_allocator #(
    parameter int POOL_SIZE = 256
) (
    input  logic          aclk,
    input  logic          aresetn,
    // operation channel
    input  logic          s_valid,
    output logic          s_ready,
    input  bpa_pkg::in_t  s_payload,
    // result channel
    output logic          m_valid,
    input  logic          m_ready,
    output bpa_pkg::out_t m_payload,
    // configuration port
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    import bpa_pkg::*;

    localparam int LINK_DEPTH = (POOL_SIZE < 256) ? POOL_SIZE : 256;
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(LINK_DEPTH);
    localparam logic [HANDLE_W-1:0] TAIL_RESET = HANDLE_W'(POOL_SIZE - 1);
    localparam logic [CNT_W-1:0] FREE_RESET =
        CNT_W'((POOL_SIZE > 511) ? 511 : POOL_SIZE);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_EXEC   = 4'b0010,
        ST_SPLICE = 4'b0100,
        ST_DONE   = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    in_t                 item_reg, item_next;
    out_t                res_reg, res_next;
    out_t                m_payload_reg, m_payload_next;
    logic                m_valid_reg, m_valid_next;
    link_wr_t            splice_wr_reg, splice_wr_next;
    logic [CNT_W-1:0]    limit_reg, limit_next;

    logic [HANDLE_W-1:0] free_head_reg, free_head_next;
    logic [HANDLE_W-1:0] free_tail_reg, free_tail_next;
    logic [CNT_W-1:0]    free_num_reg, free_num_next;
    logic [HANDLE_W-1:0] pend_head_reg, pend_head_next;
    logic [HANDLE_W-1:0] pend_tail_reg, pend_tail_next;
    logic [CNT_W-1:0]    pend_num_reg, pend_num_next;

    link_rd_t            rd_req;
    link_wr_t            wr_req;
    link_wr_t            exec_wr;
    logic [HANDLE_W-1:0] head_link;
    out_t                exec_res;
    logic                splice_need;
    logic                slot_free;
    logic                cfg_write;
    logic [CNT_W-1:0]    eff_limit;
    logic [CNT_W-1:0]    pend_inc;
    logic [CNT_W:0]      free_sum;
    logic [HANDLE_W-1:0] pend_head_new;

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_RECYCLE_LIMIT);
    assign limit_next = cfg_write ? pwdata[CNT_W-1:0] : limit_reg;

    always_comb begin
        unique case (paddr[2])
            REG_RECYCLE_LIMIT: prdata = {{(32-CNT_W){1'b0}}, limit_reg};
            default:           prdata = '0;
        endcase
    end

    // Effective recycle limit: zero acts as one, clipped at 256
    always_comb begin
        if (limit_reg == '0) begin
            eff_limit = CNT_W'(1);
        end else if (limit_reg > LIMIT_MAX) begin
            eff_limit = LIMIT_MAX;
        end else begin
            eff_limit = limit_reg;
        end
    end

    // Link store: head link read on accept
    assign s_ready   = (state_reg == ST_IDLE);
    assign rd_req.en  = s_valid && s_ready;
    assign rd_req.idx = free_head_reg;
    assign item_next  = rd_req.en ? s_payload : item_reg;

    bpa_link_store #(
        .POOL_SIZE (POOL_SIZE)
    ) u_links (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_req  (rd_req),
        .wr_req  (wr_req),
        .rd_link (head_link)
    );

    assign pend_inc      = pend_num_reg + CNT_W'(1);
    assign pend_head_new = (pend_num_reg == '0) ? item_reg.handle_in : pend_head_reg;
    assign free_sum      = {1'b0, free_num_reg} + {1'b0, pend_inc};

    // List update for the operation held in item_reg
    always_comb begin
        free_head_next = free_head_reg;
        free_tail_next = free_tail_reg;
        free_num_next  = free_num_reg;
        pend_head_next = pend_head_reg;
        pend_tail_next = pend_tail_reg;
        pend_num_next  = pend_num_reg;
        exec_wr        = '0;
        splice_need    = 1'b0;
        splice_wr_next = splice_wr_reg;
        exec_res       = '0;

        if (item_reg.op == OP_ALLOC) begin
            if (free_num_reg != '0) begin
                exec_res.handle_out = free_head_reg;
                exec_res.ok         = 1'b1;
                if (free_num_reg == CNT_W'(1)) begin
                    free_head_next = '0;
                    free_tail_next = '0;
                end else begin
                    free_head_next = head_link;
                end
                free_num_next = free_num_reg - CNT_W'(1);
            end
        end else if ({1'b0, item_reg.handle_in} < DEPTH_CNT) begin
            exec_res.ok    = 1'b1;
            exec_wr.en     = (pend_num_reg != '0);
            exec_wr.idx    = pend_tail_reg;
            exec_wr.data   = item_reg.handle_in;
            pend_head_next = pend_head_new;
            pend_tail_next = item_reg.handle_in;
            pend_num_next  = pend_inc;
            if (pend_inc >= eff_limit) begin
                // splice recycle list onto the free list tail
                if (free_num_reg == '0) begin
                    free_head_next = pend_head_new;
                end else begin
                    splice_need         = 1'b1;
                    splice_wr_next.en   = 1'b1;
                    splice_wr_next.idx  = free_tail_reg;
                    splice_wr_next.data = pend_head_new;
                end
                free_tail_next = item_reg.handle_in;
                free_num_next  = (free_sum > {1'b0, CNT_MAX}) ? CNT_MAX
                                                              : free_sum[CNT_W-1:0];
                pend_head_next = '0;
                pend_tail_next = '0;
                pend_num_next  = '0;
            end
        end
        exec_res.free_count    = free_num_next;
        exec_res.pending_count = pend_num_next;
    end

    // Link write port: list append in EXEC, splice link in SPLICE
    always_comb begin
        unique case (state_reg)
            ST_EXEC:   wr_req = exec_wr;
            ST_SPLICE: wr_req = splice_wr_reg;
            default:   wr_req = '0;
        endcase
    end

    // Sequencer and result register
    assign slot_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next     = state_reg;
        res_next       = res_reg;
        m_payload_next = m_payload_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        unique case (state_reg) inside
            ST_IDLE: begin
                if (rd_req.en) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                res_next = exec_res;
                if (splice_need) begin
                    state_next = ST_SPLICE;
                end else if (slot_free) begin
                    m_payload_next = exec_res;
                    m_valid_next   = 1'b1;
                    state_next     = ST_IDLE;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_SPLICE, ST_DONE: begin
                if (slot_free) begin
                    m_payload_next = res_reg;
                    m_valid_next   = 1'b1;
                    state_next     = ST_IDLE;
                end else begin
                    state_next = ST_DONE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and list state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_valid_reg   <= 1'b0;
            limit_reg     <= LIMIT_RESET;
            free_head_reg <= '0;
            free_tail_reg <= TAIL_RESET;
            free_num_reg  <= FREE_RESET;
            pend_head_reg <= '0;
            pend_tail_reg <= '0;
            pend_num_reg  <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            limit_reg   <= limit_next;
            if (state_reg == ST_EXEC) begin
                free_head_reg <= free_head_next;
                free_tail_reg <= free_tail_next;
                free_num_reg  <= free_num_next;
                pend_head_reg <= pend_head_next;
                pend_tail_reg <= pend_tail_next;
                pend_num_reg  <= pend_num_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        item_reg      <= item_next;
        res_reg       <= res_next;
        m_payload_reg <= m_payload_next;
        splice_wr_reg <= splice_wr_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

endmodule

>>> test/buffer_pool_allocator_test.sv
// Self-checking testbench for buffer_pool_allocator: a free-list tracker class predicts
// each result, and plain tasks drive the operation channel and the APB port.
// Depends on bpa_pkg and buffer_pool_allocator.
module buffer_pool_allocator_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bpa_pkg::*;

    localparam int POOL      = 256;
    localparam int CYCLE_CAP = 400000;

    // Tracks the free and recycle lists and queues the results they imply
    class pool_tracker;
        logic [HANDLE_W-1:0] link_mem [POOL];
        logic [HANDLE_W-1:0] free_head, free_tail, pend_head, pend_tail;
        int unsigned         free_num, pend_num;
        logic [CNT_W-1:0]    limit_reg;
        out_t                replies_due [$];
        int                  fails;

        function new();
            for (int i = 0; i < POOL; i++) link_mem[i] = HANDLE_W'(i + 1);
            free_head = '0;
            free_tail = HANDLE_W'(POOL - 1);
            free_num  = POOL;
            pend_head = '0;
            pend_tail = '0;
            pend_num  = 0;
            limit_reg = LIMIT_RESET;
            fails     = 0;
        endfunction

        // Zero acts as one; anything above the pool acts as the pool size
        function int unsigned splice_point();
            if (limit_reg == '0) return 1;
            if (limit_reg > LIMIT_MAX) return LIMIT_MAX;
            return limit_reg;
        endfunction

        function out_t note_request(in_t req);
            out_t res;
            res = '0;
            if (req.op == OP_ALLOC) begin
                // empty free list: refuse and leave the lists alone
                if (free_num != 0) begin
                    res.handle_out = free_head;
                    res.ok         = 1'b1;
                    if (free_num == 1) begin
                        free_head = '0;
                        free_tail = '0;
                    end else begin
                        free_head = link_mem[free_head];
                    end
                    free_num--;
                end
            end else begin
                // every 8-bit handle lies inside the pool, so a free is always taken
                res.ok = 1'b1;
                if (pend_num == 0) begin
                    pend_head = req.handle_in;
                end else begin
                    link_mem[pend_tail] = req.handle_in;
                end
                pend_tail = req.handle_in;
                pend_num++;
                // splice the recycle list onto the free tail, order kept
                if (pend_num >= splice_point()) begin
                    if (free_num == 0) begin
                        free_head = pend_head;
                    end else begin
                        link_mem[free_tail] = pend_head;
                    end
                    free_tail = pend_tail;
                    free_num  = free_num + pend_num;
                    if (free_num > CNT_MAX) free_num = CNT_MAX;
                    pend_num  = 0;
                    pend_head = '0;
                    pend_tail = '0;
                end
            end
            res.free_count    = CNT_W'(free_num);
            res.pending_count = CNT_W'(pend_num);
            replies_due.push_back(res);
            return res;
        endfunction

        function void check_reply(out_t got);
            out_t want;
            if (replies_due.size() == 0) begin
                $error("result transfer with nothing outstanding: %p", got);
                fails++;
                return;
            end
            want = replies_due.pop_front();
            if (got.handle_out !== want.handle_out) begin
                $error("handle_out: expected %0d, got %0d", want.handle_out, got.handle_out);
                fails++;
            end
            if (got.ok !== want.ok) begin
                $error("ok: expected %0d, got %0d", want.ok, got.ok);
                fails++;
            end
            if (got.free_count !== want.free_count) begin
                $error("free_count: expected %0d, got %0d", want.free_count, got.free_count);
                fails++;
            end
            if (got.pending_count !== want.pending_count) begin
                $error("pending_count: expected %0d, got %0d",
                       want.pending_count, got.pending_count);
                fails++;
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_t         s_payload;
    logic        m_valid;
    logic        m_ready;
    out_t        m_payload;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    pool_tracker         tracker;
    logic [HANDLE_W-1:0] granted [$];   // handles currently held by the user side
    int                  ops_taken = 0;
    int                  cycle_count = 0;
    bit                  calm = 1'b0;   // no idling on either side once set

    buffer_pool_allocator #(.POOL_SIZE(POOL)) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #5 aclk = ~aclk;

    // Result monitor and run timeout
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP) begin
            $display("CHECKS FAILED");
            $finish;
        end else if (aresetn && m_valid && m_ready) begin
            tracker.check_reply(m_payload);
        end
    end

    // Result side: random stalls, plus one long hold-off to back up the block
    initial begin
        bit held_off;
        held_off = 1'b0;
        m_ready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (!held_off && ops_taken >= 100) begin
                held_off = 1'b1;
                m_ready <= 1'b0;
                repeat (400) @(posedge aclk);
            end else if (!calm && $urandom_range(4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(6, 1)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // One operation transfer; returns at the edge it is accepted, valid left high
    task automatic send_op(input logic op, input logic [HANDLE_W-1:0] h);
        in_t  req;
        out_t due;
        int   spot [$];
        req.op        = op;
        req.handle_in = h;
        if (!calm && $urandom_range(3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= req;
        do @(posedge aclk); while (!s_ready);
        due = tracker.note_request(req);
        ops_taken++;
        if (op == OP_ALLOC) begin
            if (due.ok) granted.push_back(due.handle_out);
        end else begin
            spot = granted.find_first_index(item) with (item == h);
            if (spot.size() != 0) granted.delete(spot[0]);
        end
    endtask

    // Give back a handle we hold, or any handle when we hold none
    task automatic free_held();
        if (granted.size() == 0) begin
            send_op(OP_FREE, HANDLE_W'($urandom));
        end else begin
            send_op(OP_FREE, granted[$urandom_range(granted.size() - 1)]);
        end
    endtask

    // Mostly alloc/free of held handles; noise frees arbitrary handles
    task automatic mix_ops(input int count, input int alloc_pct, input int noise_pct);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(99) < alloc_pct) begin
                send_op(OP_ALLOC, HANDLE_W'($urandom));
            end else if ($urandom_range(99) < noise_pct) begin
                send_op(OP_FREE, HANDLE_W'($urandom));
            end else begin
                free_held();
            end
        end
    endtask

    // APB write of recycle_limit once the block has drained
    task automatic set_recycle_limit(input logic [CNT_W-1:0] val);
        s_valid <= 1'b0;
        while (tracker.replies_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_RECYCLE_LIMIT, 2'b00};
        pwdata  <= 32'(val);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tracker.limit_reg = val;
    endtask

    initial begin
        tracker   = new();
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_payload <= '0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: handle_in ignored on alloc, then build a recycle list of three
        send_op(OP_ALLOC, 8'h00);
        send_op(OP_ALLOC, 8'hFF);
        send_op(OP_ALLOC, 8'h5A);
        send_op(OP_ALLOC, 8'hA5);
        send_op(OP_FREE, 8'd0);
        send_op(OP_FREE, 8'd2);
        send_op(OP_FREE, 8'd3);
        send_op(OP_ALLOC, 8'h00);
        // limit dropped under the pending count: next free splices
        set_recycle_limit(9'd2);
        send_op(OP_FREE, 8'd1);
        set_recycle_limit(9'd1);
        free_held();
        send_op(OP_ALLOC, 8'hFF);
        send_op(OP_ALLOC, 8'h00);
        // zero behaves as one
        set_recycle_limit(9'd0);
        free_held();
        send_op(OP_ALLOC, 8'h33);
        // out-of-range limit behaves as the pool size
        set_recycle_limit(9'd511);
        free_held();
        send_op(OP_ALLOC, 8'hCC);
        free_held();

        // Random phases; the long result hold-off lands in the first
        set_recycle_limit(LIMIT_RESET);
        mix_ops(200, 50, 0);
        set_recycle_limit(9'd1);
        mix_ops(150, 55, 0);
        // alloc-heavy with the widest batch: empties the free list
        set_recycle_limit(LIMIT_MAX);
        mix_ops(320, 90, 3);
        // free-only: returns everything held, then repeated frees saturate free_count
        set_recycle_limit(9'd1);
        mix_ops(560, 0, 0);
        set_recycle_limit(CNT_W'($urandom_range(255, 2)));
        mix_ops(200, 50, 5);
        set_recycle_limit(CNT_W'($urandom));
        calm = 1'b1;
        mix_ops(200, 50, 5);
        s_valid <= 1'b0;

        while (tracker.replies_due.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (tracker.fails == 0 && tracker.replies_due.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
